/* rtl/follow_target_velocity_control_core_assert.svh */
// Assertion macros for the follow-target velocity control core.
// Used by the top level; no other dependencies.
`ifndef FOLLOW_TARGET_VELOCITY_CONTROL_CORE_ASSERT_SVH
`define FOLLOW_TARGET_VELOCITY_CONTROL_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define FTVC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ftvc assertion failed");
// next-cycle implication, disabled in reset
`define FTVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ftvc assertion failed");
`else
`define FTVC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FTVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/ftvc_pkg.sv */
// Shared types and constants for the follow-target velocity control core.
// No dependencies.
package ftvc_pkg;

    localparam int unsigned DIST_W = 16;
    localparam int unsigned BEAR_W = 16;
    localparam int unsigned GAIN_W = 12;
    localparam int unsigned TOL_W  = 15;
    localparam int unsigned SPD_W  = 13;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned FRAC_W = 10;
    localparam int unsigned PROD_W = DIST_W + GAIN_W;

    localparam logic [GAIN_W-1:0]       C_MIN_TURN_RATE = 12'd512;
    localparam logic signed [SPD_W-1:0] C_BACK_SPEED    = -13'sd512;
    localparam logic signed [SPD_W-1:0] C_MIN_TURN_S    = 13'sd512;
    localparam logic [1:0]              C_HOLD_MAX      = 2'd3;

    localparam logic [GAIN_W-1:0] RST_LINEAR_GAIN   = 12'd205;
    localparam logic [GAIN_W-1:0] RST_MIN_LINEAR    = 12'd205;
    localparam logic [GAIN_W-1:0] RST_MAX_LINEAR    = 12'd2048;
    localparam logic [DIST_W-1:0] RST_REACH_DIST    = 16'd1536;
    localparam logic [DIST_W-1:0] RST_BACK_DIST     = 16'd1024;
    localparam logic [GAIN_W-1:0] RST_ANGULAR_GAIN  = 12'd819;
    localparam logic [GAIN_W-1:0] RST_MAX_ANGULAR   = 12'd1024;
    localparam logic [TOL_W-1:0]  RST_ANGLE_TOL     = 15'd512;

    typedef enum logic [2:0] {
        REG_LINEAR_GAIN  = 3'd0,
        REG_MIN_LINEAR   = 3'd1,
        REG_MAX_LINEAR   = 3'd2,
        REG_REACH_DIST   = 3'd3,
        REG_BACK_DIST    = 3'd4,
        REG_ANGULAR_GAIN = 3'd5,
        REG_MAX_ANGULAR  = 3'd6,
        REG_ANGLE_TOL    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] linear_gain;
        logic [GAIN_W-1:0] min_linear_speed;
        logic [GAIN_W-1:0] max_linear_speed;
        logic [DIST_W-1:0] reach_distance;
        logic [DIST_W-1:0] back_distance;
        logic [GAIN_W-1:0] angular_gain;
        logic [GAIN_W-1:0] max_angular_speed;
        logic [TOL_W-1:0]  angle_tolerance;
    } t_cfg;

endpackage

/* rtl/ftvc_regs.sv */
// APB-style configuration register file of the follow-target core.
// Depends on ftvc_pkg.
module ftvc_regs
    import ftvc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.linear_gain       <= RST_LINEAR_GAIN;
            r_cfg.min_linear_speed  <= RST_MIN_LINEAR;
            r_cfg.max_linear_speed  <= RST_MAX_LINEAR;
            r_cfg.reach_distance    <= RST_REACH_DIST;
            r_cfg.back_distance     <= RST_BACK_DIST;
            r_cfg.angular_gain      <= RST_ANGULAR_GAIN;
            r_cfg.max_angular_speed <= RST_MAX_ANGULAR;
            r_cfg.angle_tolerance   <= RST_ANGLE_TOL;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_LINEAR_GAIN:  r_cfg.linear_gain       <= pwdata[GAIN_W-1:0];
                REG_MIN_LINEAR:   r_cfg.min_linear_speed  <= pwdata[GAIN_W-1:0];
                REG_MAX_LINEAR:   r_cfg.max_linear_speed  <= pwdata[GAIN_W-1:0];
                REG_REACH_DIST:   r_cfg.reach_distance    <= pwdata[DIST_W-1:0];
                REG_BACK_DIST:    r_cfg.back_distance     <= pwdata[DIST_W-1:0];
                REG_ANGULAR_GAIN: r_cfg.angular_gain      <= pwdata[GAIN_W-1:0];
                REG_MAX_ANGULAR:  r_cfg.max_angular_speed <= pwdata[GAIN_W-1:0];
                REG_ANGLE_TOL:    r_cfg.angle_tolerance   <= pwdata[TOL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_LINEAR_GAIN:  prdata = DATA_W'(r_cfg.linear_gain);
            REG_MIN_LINEAR:   prdata = DATA_W'(r_cfg.min_linear_speed);
            REG_MAX_LINEAR:   prdata = DATA_W'(r_cfg.max_linear_speed);
            REG_REACH_DIST:   prdata = DATA_W'(r_cfg.reach_distance);
            REG_BACK_DIST:    prdata = DATA_W'(r_cfg.back_distance);
            REG_ANGULAR_GAIN: prdata = DATA_W'(r_cfg.angular_gain);
            REG_MAX_ANGULAR:  prdata = DATA_W'(r_cfg.max_angular_speed);
            REG_ANGLE_TOL:    prdata = DATA_W'(r_cfg.angle_tolerance);
        endcase
    end

endmodule

/* rtl/ftvc_cmd.sv */
// Velocity command datapath: distance and bearing to speed commands and
// next hold count. Purely combinational; depends on ftvc_pkg.
module ftvc_cmd
    import ftvc_pkg::*;
(
    input  t_cfg                     i_cfg,
    input  logic [DIST_W-1:0]        i_distance,
    input  logic signed [BEAR_W-1:0] i_bearing,
    input  logic [1:0]               i_hold_cnt,
    output logic signed [SPD_W-1:0]  o_linear_speed,
    output logic signed [SPD_W-1:0]  o_angular_speed,
    output logic [1:0]               o_hold_cnt
);

    localparam int unsigned RAW_W = PROD_W - FRAC_W;

    logic [PROD_W-1:0]          w_lin_prod;
    logic [RAW_W-1:0]           w_lin_raw;
    logic [GAIN_W-1:0]          w_lin_hi;
    logic [GAIN_W-1:0]          w_lin_v;
    logic signed [SPD_W-1:0]    w_lin_dist;
    logic [BEAR_W-1:0]          w_mag;
    logic [PROD_W-1:0]          w_ang_prod;
    logic [RAW_W-1:0]           w_ang_raw;
    logic [GAIN_W-1:0]          w_ang_hi;
    logic [GAIN_W-1:0]          w_rate;
    logic signed [SPD_W-1:0]    w_rate_pos;
    logic signed [BEAR_W:0]     w_b;
    logic signed [BEAR_W:0]     w_tol;
    logic signed [BEAR_W:0]     w_half;
    logic                       w_allowed;
    logic [1:0]                 w_cnt_turn;

    // forward speed: truncated product, clamp to max then raise to min
    assign w_lin_prod = PROD_W'(i_distance) * PROD_W'(i_cfg.linear_gain);
    assign w_lin_raw  = w_lin_prod[PROD_W-1:FRAC_W];
    assign w_lin_hi   = (w_lin_raw > RAW_W'(i_cfg.max_linear_speed)) ?
                        i_cfg.max_linear_speed : w_lin_raw[GAIN_W-1:0];
    assign w_lin_v    = (w_lin_hi < i_cfg.min_linear_speed) ?
                        i_cfg.min_linear_speed : w_lin_hi;

    always_comb begin
        if (i_distance > i_cfg.reach_distance) begin
            w_lin_dist = $signed({1'b0, w_lin_v});
        end else if (i_distance < i_cfg.back_distance) begin
            w_lin_dist = C_BACK_SPEED;
        end else begin
            w_lin_dist = '0;
        end
    end

    // turn rate on the bearing magnitude, so truncation is symmetric
    assign w_mag      = i_bearing[BEAR_W-1] ? BEAR_W'(-i_bearing) : BEAR_W'(i_bearing);
    assign w_ang_prod = PROD_W'(w_mag) * PROD_W'(i_cfg.angular_gain);
    assign w_ang_raw  = w_ang_prod[PROD_W-1:FRAC_W];
    assign w_ang_hi   = (w_ang_raw > RAW_W'(i_cfg.max_angular_speed)) ?
                        i_cfg.max_angular_speed : w_ang_raw[GAIN_W-1:0];
    assign w_rate     = (w_ang_hi < C_MIN_TURN_RATE) ? C_MIN_TURN_RATE : w_ang_hi;
    assign w_rate_pos = $signed({1'b0, w_rate});

    assign w_b    = $signed({i_bearing[BEAR_W-1], i_bearing});
    assign w_tol  = $signed({2'b00, i_cfg.angle_tolerance});
    assign w_half = $signed({3'b000, i_cfg.angle_tolerance[TOL_W-1:1]});

    // turn in place only from an idle or expired hold count
    assign w_allowed  = (i_hold_cnt == 2'd0) || (i_hold_cnt == C_HOLD_MAX);
    assign w_cnt_turn = w_allowed ? 2'd0 : i_hold_cnt + 2'd1;

    always_comb begin
        o_linear_speed  = w_lin_dist;
        o_angular_speed = '0;
        o_hold_cnt      = 2'd1;
        if (i_distance == '0 && i_bearing == '0) begin
            o_linear_speed = '0;
            o_hold_cnt     = i_hold_cnt;
        end else if (w_b > w_tol) begin
            o_hold_cnt = w_cnt_turn;
            if (w_allowed) begin
                o_linear_speed  = '0;
                o_angular_speed = w_rate_pos;
            end
        end else if (w_b > w_half) begin
            o_angular_speed = w_rate_pos;
        end else if (w_b < -w_tol) begin
            o_hold_cnt = w_cnt_turn;
            if (w_allowed) begin
                o_linear_speed  = '0;
                o_angular_speed = -w_rate_pos;
            end
        end else if (w_b < -w_half) begin
            o_angular_speed = -w_rate_pos;
        end
    end

endmodule

/* rtl/follow_target_velocity_control_core.sv */
// Top level of the follow-target velocity control core: input stage,
// command datapath, result stage, hold counter. Depends on ftvc_pkg,
// ftvc_regs, ftvc_cmd and the assertion macro header.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  in       | to core   | i_in_valid / o_in_ready  | i_distance, i_bearing
//  out      | from core | o_out_valid / i_out_ready| o_linear_speed, o_angular_speed
//  config   | to core   | psel, penable / pready   | paddr, pwdata, prdata
//
// One beat per cycle sustained while the output is ready; a result passes through
// the input register and then the result register around ftvc_cmd.
// Synchronous active-low reset clears valids, the hold counter and loads
// the register defaults. A stalled output holds its beat; the input stage
// still takes a new beat whenever its content moves to the output.
`include "follow_target_velocity_control_core_assert.svh"

module follow_target_velocity_control_core
    import ftvc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [DIST_W-1:0]        i_distance,
    input  logic signed [BEAR_W-1:0] i_bearing,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [SPD_W-1:0]  o_linear_speed,
    output logic signed [SPD_W-1:0]  o_angular_speed,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready
);

    t_cfg                    w_cfg;
    logic                    r_in_valid;
    logic [DIST_W-1:0]       r_distance;
    logic signed [BEAR_W-1:0] r_bearing;
    logic                    r_out_valid;
    logic signed [SPD_W-1:0] r_lin;
    logic signed [SPD_W-1:0] r_ang;
    logic [1:0]              r_hold_cnt;
    logic [1:0]              n_hold_cnt;
    logic signed [SPD_W-1:0] n_lin;
    logic signed [SPD_W-1:0] n_ang;
    logic                    w_advance;
    logic                    w_accept;

    ftvc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ftvc_cmd u_cmd (
        .i_cfg           (w_cfg),
        .i_distance      (r_distance),
        .i_bearing       (r_bearing),
        .i_hold_cnt      (r_hold_cnt),
        .o_linear_speed  (n_lin),
        .o_angular_speed (n_ang),
        .o_hold_cnt      (n_hold_cnt)
    );

    // move the staged beat forward when the result slot is free or draining
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_accept    = i_in_valid && o_in_ready;

    assign o_out_valid     = r_out_valid;
    assign o_linear_speed  = r_lin;
    assign o_angular_speed = r_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hold_cnt  <= 2'd0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_hold_cnt  <= n_hold_cnt;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_distance <= i_distance;
            r_bearing  <= i_bearing;
        end
        if (w_advance) begin
            r_lin <= n_lin;
            r_ang <= n_ang;
        end
    end

    // hold count changes only as a beat moves to the result register
    `FTVC_ASSERT_NEXT(a_hold_stable, i_clk, i_rst_n, !w_advance, $stable(r_hold_cnt))
    // any commanded turn is at least the minimum turn rate
    `FTVC_ASSERT_NOW(a_turn_floor, i_clk, i_rst_n, o_out_valid && (o_angular_speed != '0), (o_angular_speed >= C_MIN_TURN_S) || (o_angular_speed <= -C_MIN_TURN_S))
    // the only reverse command is the back-off speed
    `FTVC_ASSERT_NOW(a_back_speed, i_clk, i_rst_n, o_out_valid && (o_linear_speed < 0), o_linear_speed == C_BACK_SPEED)

endmodule

/* bench/follow_target_velocity_control_core_tb.sv */
// Self-checking bench for follow_target_velocity_control_core: drives measurement beats,
// writes the APB registers between phases and checks each velocity command against a
// predictor kept in a small scoreboard class. Depends on ftvc_pkg and the core RTL.
`timescale 1ns / 100ps

typedef struct packed {
    logic signed [ftvc_pkg::SPD_W-1:0] linear;
    logic signed [ftvc_pkg::SPD_W-1:0] angular;
} t_velocity_cmd;

class t_velocity_scoreboard;
    logic [ftvc_pkg::GAIN_W-1:0] lin_gain;
    logic [ftvc_pkg::GAIN_W-1:0] min_lin;
    logic [ftvc_pkg::GAIN_W-1:0] max_lin;
    logic [ftvc_pkg::DIST_W-1:0] reach;
    logic [ftvc_pkg::DIST_W-1:0] back;
    logic [ftvc_pkg::GAIN_W-1:0] ang_gain;
    logic [ftvc_pkg::GAIN_W-1:0] max_ang;
    logic [ftvc_pkg::TOL_W-1:0]  tol;
    logic [1:0]                  hold;
    t_velocity_cmd               cmd_q[$];
    int                          errors;

    function new();
        lin_gain = ftvc_pkg::RST_LINEAR_GAIN;
        min_lin  = ftvc_pkg::RST_MIN_LINEAR;
        max_lin  = ftvc_pkg::RST_MAX_LINEAR;
        reach    = ftvc_pkg::RST_REACH_DIST;
        back     = ftvc_pkg::RST_BACK_DIST;
        ang_gain = ftvc_pkg::RST_ANGULAR_GAIN;
        max_ang  = ftvc_pkg::RST_MAX_ANGULAR;
        tol      = ftvc_pkg::RST_ANGLE_TOL;
        hold     = 2'd0;
        errors   = 0;
    endfunction

    function void set_reg(ftvc_pkg::t_reg_idx idx, logic [31:0] val);
        case (idx)
            ftvc_pkg::REG_LINEAR_GAIN:  lin_gain = val[ftvc_pkg::GAIN_W-1:0];
            ftvc_pkg::REG_MIN_LINEAR:   min_lin  = val[ftvc_pkg::GAIN_W-1:0];
            ftvc_pkg::REG_MAX_LINEAR:   max_lin  = val[ftvc_pkg::GAIN_W-1:0];
            ftvc_pkg::REG_REACH_DIST:   reach    = val[ftvc_pkg::DIST_W-1:0];
            ftvc_pkg::REG_BACK_DIST:    back     = val[ftvc_pkg::DIST_W-1:0];
            ftvc_pkg::REG_ANGULAR_GAIN: ang_gain = val[ftvc_pkg::GAIN_W-1:0];
            ftvc_pkg::REG_MAX_ANGULAR:  max_ang  = val[ftvc_pkg::GAIN_W-1:0];
            ftvc_pkg::REG_ANGLE_TOL:    tol      = val[ftvc_pkg::TOL_W-1:0];
            default: ;
        endcase
    endfunction

    function int turn_rate(int unsigned mag);
        int unsigned r;
        r = (mag * ang_gain) >> ftvc_pkg::FRAC_W;
        if (r > max_ang) r = max_ang;
        if (r < ftvc_pkg::C_MIN_TURN_RATE) r = ftvc_pkg::C_MIN_TURN_RATE;
        return int'(r);
    endfunction

    // clear the hold counter on a permitted turn, else advance it
    function bit turn_permitted();
        if (hold == 2'd0 || hold == ftvc_pkg::C_HOLD_MAX) begin
            hold = 2'd0;
            return 1'b1;
        end
        hold = hold + 2'd1;
        return 1'b0;
    endfunction

    function void note_meas(logic [ftvc_pkg::DIST_W-1:0] meas_dist,
                            logic signed [ftvc_pkg::BEAR_W-1:0] bear);
        int            b;
        int            tol_i;
        int            half_i;
        int unsigned   v;
        int unsigned   mag;
        int            lin;
        int            ang;
        t_velocity_cmd cmd;
        b      = bear;
        tol_i  = tol;
        half_i = tol_i >> 1;
        lin    = 0;
        ang    = 0;
        mag    = (b < 0) ? -b : b;
        if (meas_dist == '0 && b == 0) begin
            cmd_q.push_back('0);
            return;
        end
        if (meas_dist > reach) begin
            v = (int'(meas_dist) * int'(lin_gain)) >> ftvc_pkg::FRAC_W;
            if (v > max_lin) v = max_lin;
            if (v < min_lin) v = min_lin;
            lin = int'(v);
        end else if (meas_dist < back) begin
            lin = ftvc_pkg::C_BACK_SPEED;
        end
        if (b > tol_i) begin
            if (turn_permitted()) begin
                lin = 0;
                ang = turn_rate(mag);
            end
        end else if (b > half_i) begin
            hold = 2'd1;
            ang  = turn_rate(mag);
        end else if (b < -tol_i) begin
            if (turn_permitted()) begin
                lin = 0;
                ang = -turn_rate(mag);
            end
        end else if (b < -half_i) begin
            hold = 2'd1;
            ang  = -turn_rate(mag);
        end else begin
            hold = 2'd1;
        end
        cmd.linear  = lin[ftvc_pkg::SPD_W-1:0];
        cmd.angular = ang[ftvc_pkg::SPD_W-1:0];
        cmd_q.push_back(cmd);
    endfunction

    function void check_cmd(logic signed [ftvc_pkg::SPD_W-1:0] lin,
                            logic signed [ftvc_pkg::SPD_W-1:0] ang);
        t_velocity_cmd want;
        if (cmd_q.size() == 0) begin
            $display("%0t: command beat with none expected, linear %0d angular %0d",
                     $time, lin, ang);
            errors++;
            return;
        end
        want = cmd_q.pop_front();
        if (lin !== want.linear) begin
            $display("%0t: linear_speed expected %0d actual %0d", $time, want.linear, lin);
            errors++;
        end
        if (ang !== want.angular) begin
            $display("%0t: angular_speed expected %0d actual %0d", $time, want.angular, ang);
            errors++;
        end
    endfunction

    function int pending();
        return cmd_q.size();
    endfunction
endclass

module follow_target_velocity_control_core_tb;
    import ftvc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RAND_PER_SET = 180;
    localparam int NUM_SETTINGS = 9;
    localparam int NUM_DIRECTED = 25;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [DIST_W-1:0]        distance  = '0;
    logic signed [BEAR_W-1:0] bearing   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [SPD_W-1:0]  linear_speed;
    logic signed [SPD_W-1:0]  angular_speed;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [ADDR_W-1:0]        paddr     = '0;
    logic [DATA_W-1:0]        pwdata    = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    t_velocity_scoreboard sb;
    bit                 no_idle     = 1'b0;
    int                 ready_left  = 0;
    int                 turn_run    = 0;
    int                 cycle_count = 0;

    follow_target_velocity_control_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_distance     (distance),
        .i_bearing      (bearing),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_linear_speed (linear_speed),
        .o_angular_speed(angular_speed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 clk = ~clk;

    function automatic int idle_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side: alternate ready stretches with stalls
    always @(negedge clk) begin
        if (no_idle) begin
            out_ready <= 1'b1;
        end else if (ready_left == 0) begin
            if (out_ready) begin
                out_ready  <= 1'b0;
                ready_left = idle_gap() + 1;
            end else begin
                out_ready  <= 1'b1;
                ready_left = $urandom_range(1, 24);
            end
        end else begin
            ready_left--;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_cmd(linear_speed, angular_speed);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("follow_target_velocity_control_core_tb: done, errors");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_meas(logic [DIST_W-1:0] d, logic signed [BEAR_W-1:0] b);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        distance <= d;
        bearing  <= b;
        do @(posedge clk); while (!(in_valid && in_ready));
        sb.note_meas(d, b);
        @(negedge clk);
    endtask

    // hold off the sender until every command is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic write_all(int lg, int mnl, int mxl, int rd, int bd, int ag, int mxa, int at);
        write_reg(REG_LINEAR_GAIN, lg);
        write_reg(REG_MIN_LINEAR, mnl);
        write_reg(REG_MAX_LINEAR, mxl);
        write_reg(REG_REACH_DIST, rd);
        write_reg(REG_BACK_DIST, bd);
        write_reg(REG_ANGULAR_GAIN, ag);
        write_reg(REG_MAX_ANGULAR, mxa);
        write_reg(REG_ANGLE_TOL, at);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(int n);
        case (n)
            1: write_all(4095, 4095, 4095, 65535, 65535, 4095, 4095, 32767);
            2: write_all(0, 0, 0, 0, 0, 0, 0, 0);
            // crossed clamps: minimum above maximum on both speeds
            3: write_all(1500, 3000, 100, 2000, 900, 3000, 100, 700);
            // back-off distance above reach distance
            4: write_all(300, 50, 1500, 800, 6000, 600, 2500, 64);
            8: write_all(int'(RST_LINEAR_GAIN), int'(RST_MIN_LINEAR), int'(RST_MAX_LINEAR),
                         int'(RST_REACH_DIST), int'(RST_BACK_DIST), int'(RST_ANGULAR_GAIN),
                         int'(RST_MAX_ANGULAR), int'(RST_ANGLE_TOL));
            default: write_all($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), $urandom_range(0, 32767));
        endcase
    endtask

    function automatic int clip_dist(int v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    function automatic int pick_distance();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return $urandom_range(0, 65535);
        if (r < 45) return clip_dist(int'(sb.reach) + $urandom_range(0, 4) - 2);
        if (r < 65) return clip_dist(int'(sb.back) + $urandom_range(0, 4) - 2);
        if (r < 85) return $urandom_range(0, 4095);
        if (r < 92) return 0;
        return 65535;
    endfunction

    function automatic int signed_mag(int mag);
        if (mag > 32767 || $urandom_range(0, 1)) return -mag;
        return mag;
    endfunction

    // includes runs of large bearings beyond the tolerance, so the hold counter cycles
    function automatic int pick_bearing();
        int tol_i;
        int half_i;
        int r;
        int mag;
        tol_i  = sb.tol;
        half_i = tol_i >> 1;
        r      = $urandom_range(0, 99);
        if (turn_run > 0) begin
            turn_run--;
            r = 0;
        end else if (r < 8) begin
            turn_run = $urandom_range(2, 5);
        end
        if (r < 35 || (r < 60 && tol_i == 0)) begin
            if (tol_i >= 32767 || $urandom_range(0, 1))
                return -int'($urandom_range(tol_i + 1, 32768));
            return $urandom_range(tol_i + 1, 32767);
        end
        if (r < 60) return signed_mag($urandom_range(half_i + 1, tol_i));
        if (r < 72) return signed_mag($urandom_range(0, half_i));
        if (r < 85) begin
            case ($urandom_range(0, 3))
                0: mag = tol_i;
                1: mag = tol_i + 1;
                2: mag = half_i;
                default: mag = half_i + 1;
            endcase
            return signed_mag(mag);
        end
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    int dir_dist [NUM_DIRECTED] = '{0, 65535, 1537, 1536, 0, 1023, 1024, 2000, 2000, 2000,
                                    2000, 2000, 2000, 2000, 2000, 1, 1, 1, 0, 0,
                                    3000, 1600, 1537, 16'hAAAA, 16'h5555};
    int dir_bear [NUM_DIRECTED] = '{0, 0, 32767, 32767, 0, -32768, -32768, 513, 512, 257,
                                    256, -256, -257, -512, -513, -513, 513, 0, 1, -1,
                                    0, 0, 0, 16'h5555, -21846};

    initial begin
        sb = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults: zero measurement, band edges, held turns then turns in place
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_meas(DIST_W'(dir_dist[i]), BEAR_W'(dir_bear[i]));
        drain();

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s > 0) begin
                drain();
                apply_setting(s);
            end
            no_idle = (s == 4);
            for (int i = 0; i < RAND_PER_SET; i++) begin
                if ($urandom_range(0, 99) < 4)
                    send_meas('0, '0);
                else
                    send_meas(DIST_W'(pick_distance()), BEAR_W'(pick_bearing()));
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("follow_target_velocity_control_core_tb: done, clean");
        end else begin
            $display("follow_target_velocity_control_core_tb: done, errors");
        end
        $finish;
    end

endmodule
